/* rtl/core/integer_atan2_table_macros.svh */
// ----------------------------------------------------------------------------
// integer_atan2_table_macros
// Assertion macros shared by the checker files.
// ----------------------------------------------------------------------------
`ifndef INTEGER_ATAN2_TABLE_MACROS_SVH
`define INTEGER_ATAN2_TABLE_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define IAT_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("iat assertion failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define IAT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("iat assertion failed");

`endif

/* rtl/core/iat_pkg.sv */
// ----------------------------------------------------------------------------
// iat_pkg
// Shared widths, controller/datapath interface types and the tangent table.
// ----------------------------------------------------------------------------
package iat_pkg;

	localparam int CoordW = 16;
	localparam int MagW   = 15;
	localparam int NormW  = 9;
	localparam int QuoW   = 7;
	localparam int AngW   = 8;
	localparam int DivSteps = 7;

	typedef struct packed {
		logic load;
		logic shift;
		logic div_step;
		logic div_first;
		logic finish;
	} iat_cmd_t;

	typedef struct packed {
		logic den_big;
	} iat_sts_t;

	// octant angle for round(64*tan), index 0..64
	function automatic logic [5:0] tan_lut(input logic [6:0] idx);
		logic [5:0] t;
		case (idx)
			7'd0:  t = 6'd0;   7'd1:  t = 6'd1;   7'd2:  t = 6'd1;   7'd3:  t = 6'd2;
			7'd4:  t = 6'd3;   7'd5:  t = 6'd3;   7'd6:  t = 6'd4;   7'd7:  t = 6'd4;
			7'd8:  t = 6'd5;   7'd9:  t = 6'd6;   7'd10: t = 6'd6;   7'd11: t = 6'd7;
			7'd12: t = 6'd8;   7'd13: t = 6'd8;   7'd14: t = 6'd9;   7'd15: t = 6'd9;
			7'd16: t = 6'd10;  7'd17: t = 6'd11;  7'd18: t = 6'd11;  7'd19: t = 6'd12;
			7'd20: t = 6'd12;  7'd21: t = 6'd13;  7'd22: t = 6'd13;  7'd23: t = 6'd14;
			7'd24: t = 6'd15;  7'd25: t = 6'd15;  7'd26: t = 6'd16;  7'd27: t = 6'd16;
			7'd28: t = 6'd17;  7'd29: t = 6'd17;  7'd30: t = 6'd18;  7'd31: t = 6'd18;
			7'd32: t = 6'd19;  7'd33: t = 6'd19;  7'd34: t = 6'd20;  7'd35: t = 6'd20;
			7'd36: t = 6'd21;  7'd37: t = 6'd21;  7'd38: t = 6'd22;  7'd39: t = 6'd22;
			7'd40: t = 6'd23;  7'd41: t = 6'd23;  7'd42: t = 6'd24;  7'd43: t = 6'd24;
			7'd44: t = 6'd25;  7'd45: t = 6'd25;  7'd46: t = 6'd25;  7'd47: t = 6'd26;
			7'd48: t = 6'd26;  7'd49: t = 6'd27;  7'd50: t = 6'd27;  7'd51: t = 6'd27;
			7'd52: t = 6'd28;  7'd53: t = 6'd28;  7'd54: t = 6'd29;  7'd55: t = 6'd29;
			7'd56: t = 6'd29;  7'd57: t = 6'd30;  7'd58: t = 6'd30;  7'd59: t = 6'd30;
			7'd60: t = 6'd31;  7'd61: t = 6'd31;  7'd62: t = 6'd31;  7'd63: t = 6'd32;
			7'd64: t = 6'd32;
			default: t = 6'd32;
		endcase
		return t;
	endfunction

endpackage

/* rtl/core/iat_ctrl.sv */
// ----------------------------------------------------------------------------
// iat_ctrl
// Sequencer: load, normalise, seven-step division, finish into output reg.
// ----------------------------------------------------------------------------
module iat_ctrl
	import iat_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  iat_sts_t sts,
	output iat_cmd_t cmd
);

	localparam logic [1:0] StIdle = 2'd0;
	localparam logic [1:0] StNorm = 2'd1;
	localparam logic [1:0] StDiv  = 2'd2;
	localparam logic [1:0] StFin  = 2'd3;
	localparam logic [2:0] LastStep = 3'(DivSteps - 1);

	logic [1:0] state_q, state_d;
	logic [2:0] cnt_q, cnt_d;
	logic       ovalid_q, ovalid_d;

	assign in_ready  = (state_q == StIdle);
	assign out_valid = ovalid_q;

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		ovalid_d = ovalid_q && !out_ready;
		case (state_q)
			StIdle: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = StNorm;
				end
			end
			StNorm: begin
				if (sts.den_big) begin
					cmd.shift = 1'b1;
				end else begin
					cnt_d   = '0;
					state_d = StDiv;
				end
			end
			StDiv: begin
				cmd.div_step  = 1'b1;
				cmd.div_first = (cnt_q == '0);
				cnt_d = cnt_q + 3'd1;
				if (cnt_q == LastStep) begin
					state_d = StFin;
				end
			end
			StFin: begin
				if (!ovalid_q || out_ready) begin
					cmd.finish = 1'b1;
					ovalid_d   = 1'b1;
					state_d    = StIdle;
				end
			end
			default: begin
				state_d = StIdle;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= StIdle;
			cnt_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			cnt_q    <= cnt_d;
			ovalid_q <= ovalid_d;
		end
	end

endmodule

/* rtl/core/iat_dp.sv */
// ----------------------------------------------------------------------------
// iat_dp
// Datapath: magnitudes and octant fold, normaliser, restoring divider,
// rounding, table lookup and quadrant unfold.
// ----------------------------------------------------------------------------
module iat_dp
	import iat_pkg::*;
(
	input  logic                     clk,
	input  logic signed [CoordW-1:0] y_coord,
	input  logic signed [CoordW-1:0] x_coord,
	input  iat_cmd_t                 cmd,
	output iat_sts_t                 sts,
	output logic        [AngW-1:0]   angle
);

	logic [MagW-1:0]  num_q, den_q;
	logic [NormW-1:0] rem_q;
	logic [QuoW-1:0]  quo_q;
	logic             ypos_q, xpos_q, swap_q, zero_q;
	logic [AngW-1:0]  angle_q;

	logic [MagW-1:0]   my, mx;
	logic [CoordW-1:0] ny, nx;
	logic              ypos, xpos, swap;

	logic [NormW:0]   trial, trial_sub;
	logic             ge;
	logic             rnd;
	logic [QuoW-1:0]  qr, idx;
	logic [5:0]       t;
	logic [6:0]       oct;
	logic [AngW-1:0]  a8, ang;

	// magnitudes; the most negative value saturates
	always_comb begin
		ypos = (y_coord > 0);
		xpos = (x_coord > 0);
		ny   = 16'd0 - y_coord;
		nx   = 16'd0 - x_coord;
		if (ypos) begin
			my = y_coord[MagW-1:0];
		end else if (y_coord == 16'sh8000) begin
			my = '1;
		end else begin
			my = ny[MagW-1:0];
		end
		if (xpos) begin
			mx = x_coord[MagW-1:0];
		end else if (x_coord == 16'sh8000) begin
			mx = '1;
		end else begin
			mx = nx[MagW-1:0];
		end
		swap = (my > mx);
	end

	assign sts.den_big = |den_q[MagW-1:NormW];

	// one restoring division step
	always_comb begin
		trial     = cmd.div_first ? {1'b0, num_q[NormW-1:0]} : {rem_q, 1'b0};
		trial_sub = trial - {1'b0, den_q[NormW-1:0]};
		ge        = (trial >= {1'b0, den_q[NormW-1:0]});
	end

	// round, clamp, look up, unfold
	always_comb begin
		rnd = (rem_q >= (den_q[NormW-1:0] >> 1));
		qr  = quo_q + QuoW'(rnd);
		idx = (qr > 7'd64) ? 7'd64 : qr;
		t   = tan_lut(idx);
		if (zero_q) begin
			oct = '0;
		end else if (swap_q) begin
			oct = 7'd64 - {1'b0, t};
		end else begin
			oct = {1'b0, t};
		end
		a8 = {1'b0, oct};
		case ({ypos_q, xpos_q})
			2'b11:   ang = a8;
			2'b10:   ang = 8'd128 - a8;
			2'b01:   ang = 8'd0 - a8;
			default: ang = 8'd128 + a8;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			num_q  <= swap ? mx : my;
			den_q  <= swap ? my : mx;
			zero_q <= (mx == '0) && (my == '0);
			swap_q <= swap;
			ypos_q <= ypos;
			xpos_q <= xpos;
		end else if (cmd.shift) begin
			num_q <= num_q >> 1;
			den_q <= den_q >> 1;
		end
		if (cmd.div_step) begin
			rem_q <= ge ? trial_sub[NormW-1:0] : trial[NormW-1:0];
			quo_q <= {quo_q[QuoW-2:0], ge};
		end
		if (cmd.finish) begin
			angle_q <= ang;
		end
	end

	assign angle = angle_q;

endmodule

/* rtl/core/integer_atan2_table.sv */
// ----------------------------------------------------------------------------
// integer_atan2_table
// atan2(y, x) in 256 units per turn, table based, one request at a time.
// ----------------------------------------------------------------------------
// Input channel s_axis: one request carries y_coord and x_coord.
// Output channel m_axis: one angle, 0..255, per request, in request order.
// x = y = 0 gives 128.
// From input accept to m_axis_tvalid the block halves both magnitudes n times,
// where n (0..6) is the number of halvings that bring the larger magnitude
// under 512; the normaliser shifts one bit a cycle and the divider yields
// one quotient bit a cycle over 7 steps.
// The output register holds a finished angle while the next request is
// taken and worked on; a stalled receiver holds the block only at the
// finish step, until the held angle is taken.
// Reset (arst_n low) empties the block and drops any held angle.
// ----------------------------------------------------------------------------
module integer_atan2_table
	import iat_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // [15:0] y_coord, [31:16] x_coord
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata   // [7:0] angle
);

	iat_cmd_t cmd;
	iat_sts_t sts;

	iat_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	iat_dp u_dp (
		.clk     (clk),
		.y_coord (s_axis_tdata[15:0]),
		.x_coord (s_axis_tdata[31:16]),
		.cmd     (cmd),
		.sts     (sts),
		.angle   (m_axis_tdata)
	);

endmodule

/* rtl/core/iat_chk.sv */
// ----------------------------------------------------------------------------
// iat_chk
// Port-level checks on the atan2 block, bound to the top level.
// ----------------------------------------------------------------------------
`include "integer_atan2_table_macros.svh"

module iat_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [7:0]  m_axis_tdata
);

	`IAT_ASSERT_NEXT(a_busy_after_req, s_axis_tvalid && s_axis_tready, !s_axis_tready)
	`IAT_ASSERT_IMPL(a_busy_two_cycles, s_axis_tvalid && s_axis_tready, ##2 !s_axis_tready)
	`IAT_ASSERT_IMPL(a_result_ends_work, $rose(m_axis_tvalid), s_axis_tready)
	`IAT_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind integer_atan2_table iat_chk u_iat_chk (.*);
